>>> rtl/cmvg_pkg.sv
// ---------------------------------------------------------------------------
// cmvg_pkg: shared types and constants of the circle mesh vertex generator
// Configuration bundle, segment word carried front to back, register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package cmvg_pkg;

  localparam int SineTableDepth  = 1024;
  localparam int MaxSegments     = 4096;
  localparam int FifoDepth       = 4;

  localparam int PhaseW          = 16;
  localparam int DivBitsPerStage = 4;
  localparam int DivStages       = PhaseW / DivBitsPerStage;

  localparam int FillVerts       = 3;
  localparam int OutlineVerts    = 6;

  localparam logic OpFill    = 1'b0;
  localparam logic OpOutline = 1'b1;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t RegSegmentCount = 3'd0;
  localparam reg_idx_t RegRadius       = 3'd1;
  localparam reg_idx_t RegOutlineWidth = 3'd2;
  localparam reg_idx_t RegFillColor    = 3'd3;
  localparam reg_idx_t RegOutlineColor = 3'd4;

  typedef struct packed {
    logic [12:0] segment_count;
    logic [15:0] radius;
    logic [15:0] outline_width;
    logic [31:0] fill_color;
    logic [31:0] outline_color;
  } cfg_t;

  // one accepted segment with both edge phases resolved
  typedef struct packed {
    logic              op;
    logic [PhaseW-1:0] p0;
    logic [PhaseW-1:0] p1;
  } seg_job_t;

endpackage

`default_nettype wire

>>> rtl/cmvg_front.sv
// ---------------------------------------------------------------------------
// cmvg_front: segment intake and phase divider
// Drops segments that emit nothing, then computes both edge phases
// i*65536/N and (i+1)*65536/N in a pipelined restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module cmvg_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmvg_pkg::cfg_t   cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             operation_i,
  input  wire logic [11:0]      segment_index_i,
  output logic                  push_o,
  output cmvg_pkg::seg_job_t    job_o,
  input  wire logic             full_i
);

  localparam int Stages = cmvg_pkg::DivStages;

  typedef struct packed {
    logic        op;
    logic        wrap;
    logic [12:0] rem0;
    logic [12:0] rem1;
    logic [15:0] q0;
    logic [15:0] q1;
  } div_t;

  function automatic div_t div_stage(input div_t s, input logic [12:0] n);
    div_t        r;
    logic [13:0] t0;
    logic [13:0] t1;
    logic [13:0] nx;
    r  = s;
    nx = {1'b0, n};
    for (int b = 0; b < cmvg_pkg::DivBitsPerStage; b++) begin
      t0 = {r.rem0, 1'b0};
      t1 = {r.rem1, 1'b0};
      r.q0 = {r.q0[14:0], (t0 >= nx)};
      r.q1 = {r.q1[14:0], (t1 >= nx)};
      if (t0 >= nx) begin
        t0 = t0 - nx;
      end
      if (t1 >= nx) begin
        t1 = t1 - nx;
      end
      r.rem0 = t0[12:0];
      r.rem1 = t1[12:0];
    end
    return r;
  endfunction

  logic [12:0]   n;
  logic          in_range;
  logic          enabled;
  logic          take;
  logic          adv;
  logic [12:0]   idx_ext;
  logic [12:0]   idx_next;
  div_t          init;
  logic [Stages:0] vld_q;
  div_t          st_q [Stages+1];

  assign n = (32'(cfg_i.segment_count) > 32'(cmvg_pkg::MaxSegments))
           ? 13'(cmvg_pkg::MaxSegments) : cfg_i.segment_count;

  assign idx_ext  = {1'b0, segment_index_i};
  assign idx_next = idx_ext + 13'd1;
  assign in_range = idx_ext < n;
  assign enabled  = (operation_i == cmvg_pkg::OpFill)
                  ? (cfg_i.fill_color != 32'd0)
                  : ((cfg_i.outline_width != 16'd0) && (cfg_i.outline_color != 32'd0));
  assign take     = in_valid_i && in_range && enabled;

  always_comb begin
    init.op   = operation_i;
    init.wrap = (idx_next == n);   // last segment: end phase wraps to zero
    init.rem0 = idx_ext;
    init.rem1 = idx_next;
    init.q0   = '0;
    init.q1   = '0;
  end

  assign adv        = !vld_q[Stages] || !full_i;
  assign in_ready_o = adv;
  assign push_o     = vld_q[Stages] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-1:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= init;
      for (int k = 1; k <= Stages; k++) begin
        st_q[k] <= div_stage(st_q[k-1], n);
      end
    end
  end

  always_comb begin
    job_o.op = st_q[Stages].op;
    job_o.p0 = st_q[Stages].q0;
    job_o.p1 = st_q[Stages].wrap ? '0 : st_q[Stages].q1;
  end

endmodule

`default_nettype wire

>>> rtl/cmvg_fifo.sv
// ---------------------------------------------------------------------------
// cmvg_fifo: short segment queue
// Decouples the divider front from the vertex back end.
// ---------------------------------------------------------------------------
`default_nettype none

module cmvg_fifo #(
  parameter int DEPTH = cmvg_pkg::FifoDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cmvg_pkg::seg_job_t data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output cmvg_pkg::seg_job_t      data_o,
  output logic                    empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmvg_pkg::seg_job_t mem_q [DEPTH];
  logic [PtrW-1:0]    wr_q, wr_d;
  logic [PtrW-1:0]    rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cmvg_sine_rom.sv
// ---------------------------------------------------------------------------
// cmvg_sine_rom: quarter-wave sine table, two registered read ports
// Entry k is sin(k*pi/(2*DEPTH)) in Q1.15, built at elaboration from a
// Q2.30 Taylor series through x^13, rounded half up.
// ---------------------------------------------------------------------------
`default_nettype none

module cmvg_sine_rom #(
  parameter int DEPTH = cmvg_pkg::SineTableDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [$clog2(DEPTH+1)-1:0] addr_a_i,
  input  wire logic [$clog2(DEPTH+1)-1:0] addr_b_i,
  output logic [15:0]                     data_a_o,
  output logic [15:0]                     data_b_o
);

  localparam logic [63:0] PiQ30    = 64'd3373259426;
  localparam logic [63:0] TwoDepth = 64'(2 * DEPTH);

  typedef logic [15:0] rom_t [DEPTH+1];

  function automatic logic [15:0] quarter_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    x    = (64'(k) * PiQ30) / TwoDepth;
    x2   = (x * x) >> 30;
    term = x;
    s    = x;
    term = ((term * x2) >> 30) / 64'd6;   s = s - term;
    term = ((term * x2) >> 30) / 64'd20;  s = s + term;
    term = ((term * x2) >> 30) / 64'd42;  s = s - term;
    term = ((term * x2) >> 30) / 64'd72;  s = s + term;
    term = ((term * x2) >> 30) / 64'd110; s = s - term;
    term = ((term * x2) >> 30) / 64'd156; s = s + term;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k <= DEPTH; k++) begin
      t[k] = quarter_entry(k);
    end
    return t;
  endfunction

  localparam rom_t SineRom = build_rom();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= SineRom[addr_a_i];
      data_b_o <= SineRom[addr_b_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/cmvg_back.sv
// ---------------------------------------------------------------------------
// cmvg_back: vertex sequencer and position pipeline
// Walks the 3 fill or 6 outline vertices of the head segment, one a cycle if
// not stalled: table index, table read, sign and radius multiply, rounding, output.
// ---------------------------------------------------------------------------
`default_nettype none

module cmvg_back #(
  parameter int DEPTH = cmvg_pkg::SineTableDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmvg_pkg::cfg_t     cfg_i,
  input  wire cmvg_pkg::seg_job_t head_i,
  input  wire logic               head_valid_i,
  output logic                    pop_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [17:0]      pos_x_o,
  output logic signed [17:0]      pos_z_o,
  output logic [31:0]             vertex_color_o,
  output logic [16:0]             tex_u_o,
  output logic [16:0]             tex_v_o,
  output logic                    last_vertex_o
);

  localparam int          IdxW    = $clog2(DEPTH + 1);
  localparam int          ScaleW  = 14 + IdxW + 1;
  localparam logic [16:0] TexHalf = 17'd32768;

  typedef enum logic [1:0] {TexSine, TexCenter, TexZero} tex_sel_e;

  function automatic logic signed [17:0] round_q15(input logic signed [33:0] p);
    logic [33:0] mag;
    logic [33:0] rnd;
    mag = p[33] ? 34'(-p) : 34'(p);
    rnd = (mag + 34'd16384) >> 15;
    return p[33] ? -$signed(rnd[17:0]) : $signed(rnd[17:0]);
  endfunction

  // ---------------- issue ----------------
  logic               adv;
  logic [2:0]         k_q, k_d;
  logic               is_outline;
  logic [2:0]         last_k;
  logic               sel_p1;
  logic               inner;
  logic               center;
  logic               issue;
  logic [15:0]        phase;
  logic signed [16:0] r_outer;
  logic signed [16:0] r_inner;
  logic signed [16:0] rad;
  logic [ScaleW-1:0]  scaled;
  logic [IdxW-1:0]    idx;
  tex_sel_e           tsel;

  assign adv        = !out_valid_o || out_ready_i;
  assign issue      = head_valid_i && adv;
  assign is_outline = (head_i.op == cmvg_pkg::OpOutline);
  assign last_k     = is_outline ? 3'(cmvg_pkg::OutlineVerts - 1)
                                 : 3'(cmvg_pkg::FillVerts - 1);
  // outline order: outer i, outer i+1, inner i+1, inner i+1, inner i, outer i
  assign sel_p1     = is_outline ? ((k_q == 3'd1) || (k_q == 3'd2) || (k_q == 3'd3))
                                 : (k_q == 3'd1);
  assign inner      = is_outline && ((k_q == 3'd2) || (k_q == 3'd3) || (k_q == 3'd4));
  assign center     = !is_outline && (k_q == 3'd2);
  assign phase      = sel_p1 ? head_i.p1 : head_i.p0;
  assign r_outer    = $signed({1'b0, cfg_i.radius});
  assign r_inner    = r_outer - $signed({1'b0, cfg_i.outline_width});
  assign rad        = center ? '0 : (inner ? r_inner : r_outer);
  assign scaled     = ScaleW'(phase[13:0]) * ScaleW'(DEPTH) + ScaleW'(8192);
  assign idx        = scaled[14 +: IdxW];
  assign tsel       = is_outline ? TexZero : (center ? TexCenter : TexSine);
  assign pop_o      = issue && (k_q == last_k);

  always_comb begin
    k_d = k_q;
    if (issue) begin
      k_d = (k_q == last_k) ? '0 : k_q + 3'd1;
    end
  end

  // ---------------- pipeline registers ----------------
  logic               v1_q, v2_q, v3_q;
  logic [IdxW-1:0]    idx1_q;
  logic [1:0]         quad1_q, quad2_q;
  logic signed [16:0] rad1_q, rad2_q;
  logic [31:0]        col1_q, col2_q, col3_q;
  tex_sel_e           tsel1_q, tsel2_q;
  logic               last1_q, last2_q, last3_q;
  logic [15:0]        rom_a;
  logic [15:0]        rom_b;
  logic signed [33:0] px3_q, pz3_q;
  logic [16:0]        u3_q, v3tex_q;

  // table read from the registered index lines up with stage 2
  cmvg_sine_rom #(.DEPTH(DEPTH)) u_rom (
    .clk_i    (clk_i),
    .en_i     (adv),
    .addr_a_i (idx1_q),
    .addr_b_i (IdxW'(DEPTH) - idx1_q),
    .data_a_o (rom_a),
    .data_b_o (rom_b)
  );

  // ---------------- sign, multiply ----------------
  logic [15:0]        sin_mag;
  logic [15:0]        cos_mag;
  logic               sin_neg;
  logic               cos_neg;
  logic signed [16:0] sin_s;
  logic signed [16:0] cos_s;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;

  // cosine reads quadrant+1 at the same offset
  assign sin_mag = quad2_q[0] ? rom_b : rom_a;
  assign cos_mag = quad2_q[0] ? rom_a : rom_b;
  assign sin_neg = quad2_q[1];
  assign cos_neg = quad2_q[1] ^ quad2_q[0];
  assign sin_s   = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_s   = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  always_comb begin
    case (tsel2_q)
      TexSine: begin
        tex_u = sin_neg ? TexHalf - {1'b0, sin_mag} : TexHalf + {1'b0, sin_mag};
        tex_v = cos_neg ? TexHalf - {1'b0, cos_mag} : TexHalf + {1'b0, cos_mag};
      end
      TexCenter: begin
        tex_u = TexHalf;
        tex_v = TexHalf;
      end
      default: begin
        tex_u = '0;
        tex_v = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      k_q <= k_d;
      if (adv) begin
        v1_q        <= issue;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        out_valid_o <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx1_q         <= idx;
      quad1_q        <= phase[15:14];
      rad1_q         <= rad;
      col1_q         <= is_outline ? cfg_i.outline_color : cfg_i.fill_color;
      tsel1_q        <= tsel;
      last1_q        <= (k_q == last_k);

      quad2_q        <= quad1_q;
      rad2_q         <= rad1_q;
      col2_q         <= col1_q;
      tsel2_q        <= tsel1_q;
      last2_q        <= last1_q;

      px3_q          <= 34'(rad2_q) * 34'(sin_s);
      pz3_q          <= 34'(rad2_q) * 34'(cos_s);
      u3_q           <= tex_u;
      v3tex_q        <= tex_v;
      col3_q         <= col2_q;
      last3_q        <= last2_q;

      pos_x_o        <= round_q15(px3_q);
      pos_z_o        <= round_q15(pz3_q);
      tex_u_o        <= u3_q;
      tex_v_o        <= v3tex_q;
      vertex_color_o <= col3_q;
      last_vertex_o  <= last3_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/circle_mesh_vertex_generator.sv
// ---------------------------------------------------------------------------
// circle_mesh_vertex_generator: triangle vertices for one circle segment
// On its way to its first vertex an accepted segment passes the front divider,
// the segment queue and the back pipeline. Throughput: one vertex per cycle
// while out_ready_i is high, three for a fill segment and six for an outline
// segment; segments that emit nothing are absorbed at one per cycle by the front divider while in_ready_o is high.
// Reset: configuration registers clear to zero, all pipelines empty.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_mesh_vertex_generator #(
  parameter int SINE_TABLE_DEPTH = cmvg_pkg::SineTableDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          operation_i,
  input  wire logic [11:0]   segment_index_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic signed [17:0] pos_x_o,
  output logic signed [17:0] pos_z_o,
  output logic [31:0]        vertex_color_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic               last_vertex_o
);

  cmvg_pkg::cfg_t     cfg_q;
  cmvg_pkg::seg_job_t push_word;
  cmvg_pkg::seg_job_t head_word;
  logic               push;
  logic               full;
  logic               empty;
  logic               pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cmvg_pkg::RegSegmentCount: cfg_q.segment_count <= cfg_data_i[12:0];
        cmvg_pkg::RegRadius:       cfg_q.radius        <= cfg_data_i[15:0];
        cmvg_pkg::RegOutlineWidth: cfg_q.outline_width <= cfg_data_i[15:0];
        cmvg_pkg::RegFillColor:    cfg_q.fill_color    <= cfg_data_i;
        cmvg_pkg::RegOutlineColor: cfg_q.outline_color <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmvg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .segment_index_i (segment_index_i),
    .push_o          (push),
    .job_o           (push_word),
    .full_i          (full)
  );

  cmvg_fifo #(.DEPTH(cmvg_pkg::FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_word),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_word),
    .empty_o (empty)
  );

  cmvg_back #(.DEPTH(SINE_TABLE_DEPTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head_word),
    .head_valid_i   (!empty),
    .pop_o          (pop),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .pos_x_o        (pos_x_o),
    .pos_z_o        (pos_z_o),
    .vertex_color_o (vertex_color_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .last_vertex_o  (last_vertex_o)
  );

endmodule

`default_nettype wire
